[rtl/pip_pkg.sv]
// Shared constants and types for the point-in-polygon crossing-parity tester.
package pip_pkg;

	// Storage and coordinate sizes
	localparam int MAX_VERTICES = 256;
	localparam int COORD_BITS   = 16;
	localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
	localparam int INDEX_BITS   = 8;
	localparam int COUNT_BITS   = 9;
	localparam int VERT_BITS    = 2 * COORD_BITS;
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int PROD_BITS    = 2 * DIFF_BITS;

	// Item modes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Query sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} pip_state_t;

endpackage

[rtl/pip_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface pip_in_if;
	logic                                valid;
	logic                                ready;
	logic                                mode;
	logic [pip_pkg::INDEX_BITS-1:0]      vertex_index;
	logic signed [pip_pkg::COORD_BITS-1:0] coord_x;
	logic signed [pip_pkg::COORD_BITS-1:0] coord_y;

	modport source (output valid, mode, vertex_index, coord_x, coord_y, input ready);
	modport sink (input valid, mode, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_out_if;
	logic valid;
	logic ready;
	logic inside_res;

	modport source (output valid, inside_res, input ready);
	modport sink (input valid, inside_res, output ready);
endinterface

[rtl/pip_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/point_in_polygon_test.sv]
// Point-in-polygon tester: vertex store, edge sequencer and crossing pipeline.
//
// Usage:
// - item_in carries load items (mode 0) and query items (mode 1). A load writes
//   coord_x/coord_y into the vertex store at vertex_index; it gives no result.
//   A query gives one item on result_out holding inside_res.
// - cfg_wr_en/cfg_wr_data set the vertex count; write it only while idle.
//   Counts above the store depth are clamped to the depth.
// - A query walks the store once, reading one vertex per cycle from the single
//   read port of the vertex RAM; each edge then passes a difference stage, a
//   product stage and the parity update. With fewer than three vertices it
//   skips the walk and answers 0.
// - item_in.ready is low for the whole of a query, so queries run one at a
//   time; loads are taken every cycle while the block is idle.
// - result_out is a registered output. A stalled receiver holds the result and
//   the block keeps accepting loads; a finished query waits for the slot.
// - arst_n clears the sequencer, the vertex count and the output valid. Store
//   contents are undefined until written.
module point_in_polygon_test (
	input  logic                            clk,
	input  logic                            arst_n,
	pip_in_if.sink                          item_in,
	pip_out_if.source                       result_out,
	input  logic                            cfg_wr_en,
	input  logic [pip_pkg::COUNT_BITS-1:0]  cfg_wr_data
);

	pip_pkg::pip_state_t state_q, state_d;

	logic [pip_pkg::COUNT_BITS-1:0] count_q;
	logic [pip_pkg::COUNT_BITS-1:0] n_eff;
	logic [pip_pkg::COUNT_BITS-1:0] n_q;
	logic [pip_pkg::COUNT_BITS-1:0] iss_q;
	logic signed [pip_pkg::COORD_BITS-1:0] px_q, py_q;

	logic                            accept;
	logic                            ram_we;
	logic [pip_pkg::ADDR_BITS-1:0]   ram_raddr;
	logic [pip_pkg::VERT_BITS-1:0]   ram_rdata;
	logic [pip_pkg::VERT_BITS-1:0]   prev_q;

	logic start_run, start_short, issue, out_load;

	logic v_s1, first_s1;
	logic v_s2, q_s2;
	logic signed [pip_pkg::DIFF_BITS-1:0] a_s2, b_s2, c_s2, d_s2;
	logic v_s3, q_s3, neg_s3;
	logic signed [pip_pkg::PROD_BITS-1:0] p1_s3, p2_s3;
	logic flag_q;

	logic out_valid_q, out_res_q;

	// Clamp the configured count to the store depth
	assign n_eff = (count_q > pip_pkg::COUNT_BITS'(pip_pkg::MAX_VERTICES))
		? pip_pkg::COUNT_BITS'(pip_pkg::MAX_VERTICES) : count_q;

	assign accept = item_in.valid && item_in.ready;
	assign ram_we = accept && (item_in.mode == pip_pkg::MODE_LOAD)
		&& (32'(item_in.vertex_index) < 32'(pip_pkg::MAX_VERTICES));

	// Vertex store, x in the upper half and y in the lower half
	pip_ram #(
		.WIDTH (pip_pkg::VERT_BITS),
		.DEPTH (pip_pkg::MAX_VERTICES)
	) u_vertex_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (item_in.vertex_index[pip_pkg::ADDR_BITS-1:0]),
		.wdata ({item_in.coord_x, item_in.coord_y}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequence the edge walk: next state, handshake and read address
	always_comb begin
		state_d       = state_q;
		item_in.ready = 1'b0;
		start_run     = 1'b0;
		start_short   = 1'b0;
		issue         = 1'b0;
		out_load      = 1'b0;
		ram_raddr     = (iss_q == '0) ? pip_pkg::ADDR_BITS'(n_q - 1'b1)
			: pip_pkg::ADDR_BITS'(iss_q - 1'b1);
		case (state_q)
			pip_pkg::ST_IDLE: begin
				item_in.ready = 1'b1;
				if (accept && item_in.mode == pip_pkg::MODE_QUERY) begin
					if (n_eff < pip_pkg::COUNT_BITS'(3)) begin
						start_short = 1'b1;
						state_d     = pip_pkg::ST_FINISH;
					end else begin
						start_run = 1'b1;
						state_d   = pip_pkg::ST_RUN;
					end
				end
			end
			pip_pkg::ST_RUN: begin
				issue = 1'b1;
				if (iss_q == n_q) begin
					state_d = pip_pkg::ST_DRAIN;
				end
			end
			pip_pkg::ST_DRAIN: begin
				if (!v_s1 && !v_s2 && !v_s3) begin
					state_d = pip_pkg::ST_FINISH;
				end
			end
			pip_pkg::ST_FINISH: begin
				if (!out_valid_q || result_out.ready) begin
					out_load = 1'b1;
					state_d  = pip_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pip_pkg::ST_IDLE;
			end
		endcase
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pip_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Take config writes and latch the query
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			n_q     <= '0;
			iss_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				count_q <= cfg_wr_data;
			end
			if (start_run) begin
				n_q   <= n_eff;
				iss_q <= '0;
			end else if (issue) begin
				iss_q <= iss_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_run) begin
			px_q <= item_in.coord_x;
			py_q <= item_in.coord_y;
		end
	end

	// Track which reads return edge ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
		end else begin
			v_s1     <= issue;
			first_s1 <= issue && (iss_q == '0);
			v_s2     <= v_s1 && !first_s1;
			v_s3     <= v_s2;
		end
	end

	// Form edge differences from the previous vertex (j) and this one (i)
	always_ff @(posedge clk) begin
		logic signed [pip_pkg::COORD_BITS-1:0] xi, yi, xj, yj;
		logic straddle, x_ok;
		xi = ram_rdata[pip_pkg::VERT_BITS-1:pip_pkg::COORD_BITS];
		yi = ram_rdata[pip_pkg::COORD_BITS-1:0];
		xj = prev_q[pip_pkg::VERT_BITS-1:pip_pkg::COORD_BITS];
		yj = prev_q[pip_pkg::COORD_BITS-1:0];
		straddle = ((yi < py_q) && (yj >= py_q)) || ((yj < py_q) && (yi >= py_q));
		x_ok     = (xi <= px_q) || (xj <= px_q);
		if (v_s1) begin
			prev_q <= ram_rdata;
		end
		q_s2 <= straddle && x_ok;
		a_s2 <= pip_pkg::DIFF_BITS'(py_q) - pip_pkg::DIFF_BITS'(yi);
		b_s2 <= pip_pkg::DIFF_BITS'(xj) - pip_pkg::DIFF_BITS'(xi);
		c_s2 <= pip_pkg::DIFF_BITS'(px_q) - pip_pkg::DIFF_BITS'(xi);
		d_s2 <= pip_pkg::DIFF_BITS'(yj) - pip_pkg::DIFF_BITS'(yi);
	end

	// Multiply both sides of the crossing compare
	always_ff @(posedge clk) begin
		p1_s3  <= a_s2 * b_s2;
		p2_s3  <= c_s2 * d_s2;
		neg_s3 <= d_s2[pip_pkg::DIFF_BITS-1];
		q_s3   <= q_s2;
	end

	// Toggle the parity when the crossing lies left of the point
	always_ff @(posedge clk or negedge arst_n) begin
		logic [pip_pkg::PROD_BITS:0] diff;
		logic left;
		diff = {p1_s3[pip_pkg::PROD_BITS-1], p1_s3}
			- {p2_s3[pip_pkg::PROD_BITS-1], p2_s3};
		left = neg_s3 ? (!diff[pip_pkg::PROD_BITS] && (diff != '0))
			: diff[pip_pkg::PROD_BITS];
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (start_run || start_short) begin
			flag_q <= 1'b0;
		end else if (v_s3 && q_s3 && left) begin
			flag_q <= !flag_q;
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_res_q <= flag_q;
		end
	end

	assign result_out.valid      = out_valid_q;
	assign result_out.inside_res = out_res_q;

	// Checks on the sequencer and pipeline
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != pip_pkg::ST_IDLE) |-> !item_in.ready)
		else $error("input ready while a query is in progress");

	a_reads_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == pip_pkg::ST_RUN || state_q == pip_pkg::ST_DRAIN))
		else $error("read data returned outside the edge walk");

	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pip_pkg::ST_FINISH) |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("result taken before the pipeline drained");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pip_pkg::ST_RUN) |-> (iss_q <= n_q))
		else $error("read issue count ran past the vertex count");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_out.ready) |=> (out_valid_q && $stable(out_res_q)))
		else $error("stalled result changed");

endmodule

[sim/pip_score_pkg.sv]
// Scoreboard for the point-in-polygon tester: vertex store copy, parity predictor, result check.
package pip_score_pkg;
	import pip_pkg::*;

	class pip_scoreboard;
		logic signed [COORD_BITS-1:0] store_x [MAX_VERTICES];
		logic signed [COORD_BITS-1:0] store_y [MAX_VERTICES];
		bit                           loaded  [MAX_VERTICES];
		logic [COUNT_BITS-1:0]        vertex_count;
		bit                           parity_q [$];
		int unsigned                  loads;
		int unsigned                  queries;
		int unsigned                  results;
		int unsigned                  mismatches;

		function new();
			foreach (store_x[k]) begin
				store_x[k] = '0;
				store_y[k] = '0;
				loaded[k]  = 1'b0;
			end
			vertex_count = '0;
			loads        = 0;
			queries      = 0;
			results      = 0;
			mismatches   = 0;
		endfunction

		function void set_count(logic [COUNT_BITS-1:0] value);
			vertex_count = value;
		endfunction

		// Crossing parity of the point against the polygon in store entries 0 .. n-1
		function bit crossing_parity(logic signed [COORD_BITS-1:0] qx,
				logic signed [COORD_BITS-1:0] qy);
			longint px, py, xi, yi, xj, yj, dy, lhs, rhs;
			int     n, i, j;
			bit     flag, left;
			px   = qx;
			py   = qy;
			flag = 1'b0;
			n    = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
			if (n < 3)
				return 1'b0;
			j = n - 1;
			for (i = 0; i < n; i++) begin
				xi = store_x[i];
				yi = store_y[i];
				xj = store_x[j];
				yj = store_y[j];
				// half-open straddle of the query y, with one end at or left of the query x
				if (((yi < py && yj >= py) || (yj < py && yi >= py)) && (xi <= px || xj <= px)) begin
					dy   = yj - yi;
					lhs  = (py - yi) * (xj - xi);
					rhs  = (px - xi) * dy;
					// crossing x strictly left of px; reverse the sense for a falling edge
					left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
					if (left)
						flag = !flag;
				end
				j = i;
			end
			return flag;
		endfunction

		// Apply an accepted item: loads update the store, queries queue a flag
		function void note_item(logic mode, logic [INDEX_BITS-1:0] idx,
				logic signed [COORD_BITS-1:0] cx, logic signed [COORD_BITS-1:0] cy);
			if (mode == MODE_LOAD) begin
				store_x[idx] = cx;
				store_y[idx] = cy;
				loaded[idx]  = 1'b1;
				loads++;
			end else begin
				parity_q.insert(parity_q.size(), crossing_parity(cx, cy));
				queries++;
			end
		endfunction

		function void check_result(logic inside_res);
			bit want;
			results++;
			if (parity_q.size() == 0) begin
				$error("inside_res: result item with nothing expected, actual %0b", inside_res);
				mismatches++;
			end else begin
				want = parity_q.pop_front();
				if (inside_res !== want) begin
					$error("inside_res mismatch: expected %0b, actual %0b", want, inside_res);
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return parity_q.size();
		endfunction
	endclass

endpackage

[sim/testbench.sv]
// Top-level testbench for point_in_polygon_test: stimulus, handshakes and final verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pip_pkg::*;
	import pip_score_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned RANDOM_ITEMS  = 1900;
	localparam int          SETTLE_CYCLES = 16;
	localparam int          HOLD_CYCLES   = 400;
	localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [COUNT_BITS-1:0] cfg_wr_data;

	pip_in_if  item_if ();
	pip_out_if res_if ();

	point_in_polygon_test u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_if),
		.result_out (res_if),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	pip_scoreboard board = new();
	int unsigned   cycles = 0;
	int unsigned   items_sent = 0;
	int unsigned   count_writes = 0;
	int            gap_pct = 29;
	int            hold_left = 0;
	int unsigned   next_hold_at = 150;

	always #5ns clk = ~clk;

	// Abort on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// Check each result item; drive ready with random stalls and the odd long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready)
				board.check_result(res_if.inside_res);
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else if (board.results >= next_hold_at) begin
				hold_left    = HOLD_CYCLES;
				next_hold_at += 500;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(0, 99) >= gap_pct);
			end
		end
	end

	function automatic logic signed [COORD_BITS-1:0] rand_coord(int unsigned span);
		int v;
		if (span >= 32768)
			return COORD_BITS'($urandom);
		v = int'($urandom_range(0, 2 * span)) - int'(span);
		return COORD_BITS'(v);
	endfunction

	// Offer one item and wait for it to be taken
	task automatic send_item(input logic mode, input logic [INDEX_BITS-1:0] idx,
			input logic signed [COORD_BITS-1:0] cx, input logic signed [COORD_BITS-1:0] cy);
		while ($urandom_range(0, 99) < gap_pct) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid        <= 1'b1;
		item_if.mode         <= mode;
		item_if.vertex_index <= idx;
		item_if.coord_x      <= cx;
		item_if.coord_y      <= cy;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		board.note_item(mode, idx, cx, cy);
		items_sent++;
	endtask

	// Hold the input until every expected result is back, then let the block settle
	task automatic drain_results();
		item_if.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [COUNT_BITS-1:0] value);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.set_count(value);
		count_writes++;
	endtask

	task automatic run_directed();
		// empty polygon after reset
		send_item(MODE_QUERY, '1, C_MIN, C_MAX);
		// full-range square, plus a stray vertex at the top of the store
		write_count(4);
		send_item(MODE_LOAD, 8'd0, C_MIN, C_MIN);
		send_item(MODE_LOAD, 8'd1, C_MAX, C_MIN);
		send_item(MODE_LOAD, 8'd2, C_MAX, C_MAX);
		send_item(MODE_LOAD, 8'd3, C_MIN, C_MAX);
		send_item(MODE_LOAD, '1, C_MAX, C_MIN);
		send_item(MODE_QUERY, 8'd0, 16'sd0, 16'sd0);
		send_item(MODE_QUERY, 8'd0, C_MIN, C_MIN);
		send_item(MODE_QUERY, 8'd0, C_MAX, C_MAX);
		send_item(MODE_QUERY, 8'd0, C_MIN, 16'sd0);
		send_item(MODE_QUERY, 8'd0, C_MAX, 16'sd0);
		send_item(MODE_QUERY, 8'd0, 16'sd0, C_MAX);
		send_item(MODE_QUERY, 8'd0, 16'sd0, C_MIN);
		// slanted triangle: rising and falling edges, queries on vertex rows
		write_count(3);
		send_item(MODE_LOAD, 8'd0, 16'sd0, C_MIN);
		send_item(MODE_LOAD, 8'd1, C_MAX, C_MAX);
		send_item(MODE_LOAD, 8'd2, C_MIN, 16'sd0);
		send_item(MODE_QUERY, 8'd0, 16'sd0, 16'sd0);
		send_item(MODE_QUERY, 8'd0, C_MIN, 16'sd0);
		send_item(MODE_QUERY, 8'd0, 16'sd16, C_MIN);
		send_item(MODE_QUERY, 8'd0, 16'sd16383, 16'sd0);
		// too few vertices
		write_count(2);
		send_item(MODE_QUERY, 8'd0, 16'sd0, 16'sd0);
		write_count(0);
		send_item(MODE_QUERY, 8'd0, 16'sd1, -16'sd1);
	endtask

	task automatic run_phase(input int phase_no);
		int unsigned                  want, eff, span, queries, k, pick, v;
		logic signed [COORD_BITS-1:0] qx, qy;
		// pick a vertex count: a few large or clamped settings, mostly small polygons
		if (phase_no == 10) begin
			want = MAX_VERTICES;
		end else if (phase_no == 30) begin
			want = 2**COUNT_BITS - 1;
		end else if (phase_no == 50) begin
			want = $urandom_range(MAX_VERTICES + 1, 2**COUNT_BITS - 2);
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 6)
				want = $urandom_range(0, 2);
			else if (pick < 90)
				want = $urandom_range(3, 12);
			else
				want = $urandom_range(13, 48);
		end
		write_count(COUNT_BITS'(want));
		eff = (want > MAX_VERTICES) ? MAX_VERTICES : want;
		case ($urandom_range(0, 2))
			0: span = 8;
			1: span = 2000;
			default: span = 32768;
		endcase
		// fresh vertices for small polygons; for large ones fill gaps and touch up a few
		for (k = 0; k < eff; k++)
			if (eff <= 64 || !board.loaded[k])
				send_item(MODE_LOAD, INDEX_BITS'(k), rand_coord(span), rand_coord(span));
		if (eff > 64)
			repeat (16)
				send_item(MODE_LOAD, INDEX_BITS'($urandom_range(0, eff - 1)),
					rand_coord(span), rand_coord(span));
		queries = (eff > 64) ? 5 : $urandom_range(4, 20);
		repeat (queries) begin
			// stray load anywhere in the store
			if ($urandom_range(0, 9) == 0)
				send_item(MODE_LOAD, INDEX_BITS'($urandom_range(0, 255)),
					COORD_BITS'($urandom), COORD_BITS'($urandom));
			if ($urandom_range(0, 99) == 0)
				drain_results();
			pick = (eff == 0) ? 0 : $urandom_range(0, 4);
			v    = (eff == 0) ? 0 : $urandom_range(0, eff - 1);
			case (pick)
				2: begin
					qx = rand_coord(span);
					qy = board.store_y[v];
				end
				3: begin
					qx = board.store_x[v];
					qy = board.store_y[v];
				end
				4: begin
					qx = COORD_BITS'($urandom);
					qy = COORD_BITS'($urandom);
				end
				default: begin
					qx = rand_coord(span);
					qy = rand_coord(span);
				end
			endcase
			send_item(MODE_QUERY, INDEX_BITS'($urandom_range(0, 255)), qx, qy);
		end
	endtask

	initial begin
		int unsigned random_start;
		int          phase_no;
		arst_n               = 1'b0;
		cfg_wr_en            = 1'b0;
		cfg_wr_data          = '0;
		item_if.valid        = 1'b0;
		item_if.mode         = MODE_LOAD;
		item_if.vertex_index = '0;
		item_if.coord_x      = '0;
		item_if.coord_y      = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// random phases; a run of phases in the middle has no gaps on either side
		random_start = items_sent;
		phase_no     = 0;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			phase_no++;
			gap_pct = (phase_no >= 20 && phase_no < 28) ? 0 : 29;
			run_phase(phase_no);
		end

		drain_results();
		repeat (40) @(posedge clk);
		$display("Covered %0d loads and %0d queries over %0d vertex-count settings;",
			board.loads, board.queries, count_writes);
		$display("%0d results checked, %0d mismatches.", board.results, board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[point_in_polygon_test.f]
rtl/pip_pkg.sv
rtl/pip_if.sv
rtl/pip_ram.sv
rtl/point_in_polygon_test.sv
sim/pip_score_pkg.sv
sim/testbench.sv
